/* hw/rtl/ssmt_pkg.sv */
// Shared types and constants for the sorted set membership table.
// Holds the request/result structs, operation and status codes, and default sizes.
// No dependencies.
package ssmt_pkg;

  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_TAXA_DEF = 64;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_MAP      = 3'd1,
    OP_LOOKUP   = 3'd2,
    OP_COMP_SUP = 3'd3,
    OP_COMP     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } status_e;

  typedef enum logic {
    REG_CLUSTER_COUNT = 1'b0,
    REG_TAXA_COUNT    = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_CHECK,
    S_IDCHK
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  position;
    logic [63:0] members;
    logic [63:0] superset;
    logic [7:0]  map_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cluster_id;
  } out_t;

endpackage

/* hw/rtl/ssmt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ssmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sorted_set_membership_table.sv */
// Sorted set membership table: jump table over sorted taxon sets with id lookup.
// Map, out-of-range and unknown items finish straight from idle; a load steps through the
// taxa and a query walks them and then checks them, bound by the jump table's single read
// port (one dependent read per taxon, then one read per taxon for the exact-match check).
// A new item is taken only while idle; busy covers loads and queries until done shows.
// Synchronous reset: no item in flight, registers at their reset values, all ids unmapped.
module sorted_set_membership_table #(
  parameter int MAX_SETS = ssmt_pkg::MAX_SETS_DEF,
  parameter int MAX_TAXA = ssmt_pkg::MAX_TAXA_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ssmt_pkg::in_t  request,
  output logic           done,
  output ssmt_pkg::out_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [8:0]     cfg_data
);

  localparam int RW     = $clog2(MAX_SETS);
  localparam int TW     = $clog2(MAX_TAXA);
  localparam int CW     = $clog2(MAX_TAXA + 1);
  localparam int IDS    = (MAX_SETS < 256) ? MAX_SETS : 256;
  localparam int IW     = $clog2(IDS);
  localparam int JDEPTH = MAX_SETS * (1 << TW);
  localparam logic [9:0] SETS_LIM = 10'((MAX_SETS > 511) ? 511 : MAX_SETS);
  localparam logic [6:0] TAXA_LIM = 7'(MAX_TAXA);

  ssmt_pkg::state_e state, state_next;

  logic [8:0]          cfg_sets;
  logic [6:0]          cfg_taxa;
  logic [MAX_TAXA-1:0] rv_valid, rv_valid_next;
  logic [IDS-1:0]      id_valid, id_valid_next;
  logic                pend, pend_next;
  logic                done_next;

  logic [CW-1:0]       cnt, cnt_next;
  logic [TW-1:0]       lt, lt_next;
  logic [RW-1:0]       row, row_next;
  logic [MAX_TAXA-1:0] qset, qset_next;
  logic                match, match_next;
  ssmt_pkg::out_t      result_next;

  logic [9:0]          sets_eff;
  logic [6:0]          taxa_eff;
  logic [CW-1:0]       taxa_n;
  logic [9:0]          pos_ext;
  logic [TW-1:0]       cnt_t;
  logic [RW-1:0]       walk_row;
  logic [RW-1:0]       old_run;
  logic [RW-1:0]       new_run;
  logic [63:0]         qset_raw;
  logic                row_mapped;

  logic                jump_we;
  logic [RW+TW-1:0]    jump_waddr, jump_raddr;
  logic [RW-1:0]       jump_rdata;
  logic                run_we;
  logic [RW-1:0]       run_rdata;
  logic                id_we;
  logic [IW-1:0]       id_waddr;
  logic [7:0]          id_rdata;

  ssmt_ram #(.WIDTH(RW), .DEPTH(JDEPTH)) u_jump (
    .clk   (clk),
    .we    (jump_we),
    .waddr (jump_waddr),
    .wdata (new_run),
    .raddr (jump_raddr),
    .rdata (jump_rdata)
  );

  ssmt_ram #(.WIDTH(RW), .DEPTH(MAX_TAXA)) u_run (
    .clk   (clk),
    .we    (run_we),
    .waddr (lt),
    .wdata (new_run),
    .raddr (cnt_t),
    .rdata (run_rdata)
  );

  ssmt_ram #(.WIDTH(8), .DEPTH(IDS)) u_ids (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (request.map_value),
    .raddr (row[IW-1:0]),
    .rdata (id_rdata)
  );

  assign busy      = (state != ssmt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign sets_eff = ({1'b0, cfg_sets} > SETS_LIM) ? SETS_LIM : {1'b0, cfg_sets};
  assign taxa_eff = (cfg_taxa > TAXA_LIM) ? TAXA_LIM : cfg_taxa;
  assign taxa_n   = CW'(taxa_eff);
  assign pos_ext  = {2'b00, request.position};
  assign cnt_t    = cnt[TW-1:0];
  assign id_waddr = IW'(request.position);

  // Take the jump target straight from the RAM when the last taxon jumped.
  assign walk_row = pend ? jump_rdata : row;

  assign old_run = rv_valid[lt] ? run_rdata : '0;
  assign new_run = qset[lt] ? row : old_run;

  assign row_mapped = ({1'b0, row} < (RW + 1)'(IDS)) && id_valid[row[IW-1:0]];

  always_comb begin
    case (ssmt_pkg::op_e'(request.operation))
      ssmt_pkg::OP_COMP_SUP: qset_raw = request.superset & ~request.members;
      ssmt_pkg::OP_COMP:     qset_raw = ~request.members;
      default:               qset_raw = request.members;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssmt_pkg::S_IDLE;
      cfg_sets <= 9'd1;
      cfg_taxa <= 7'd64;
      rv_valid <= '0;
      id_valid <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      rv_valid <= rv_valid_next;
      id_valid <= id_valid_next;
      pend     <= pend_next;
      done     <= done_next;
      if (cfg_valid) begin
        case (ssmt_pkg::reg_e'(cfg_index))
          ssmt_pkg::REG_CLUSTER_COUNT: cfg_sets <= cfg_data;
          ssmt_pkg::REG_TAXA_COUNT:    cfg_taxa <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    lt     <= lt_next;
    row    <= row_next;
    qset   <= qset_next;
    match  <= match_next;
    result <= result_next;
  end

  always_comb begin
    state_next    = state;
    rv_valid_next = rv_valid;
    id_valid_next = id_valid;
    pend_next     = 1'b0;
    done_next     = 1'b0;
    cnt_next      = cnt;
    lt_next       = lt;
    row_next      = row;
    qset_next     = qset;
    match_next    = match;
    result_next   = result;
    jump_we       = 1'b0;
    jump_waddr    = {row, lt};
    jump_raddr    = {row, cnt_t};
    run_we        = 1'b0;
    id_we         = 1'b0;

    case (state)
      ssmt_pkg::S_IDLE: begin
        if (start) begin
          result_next.status     = ssmt_pkg::STAT_DONE;
          result_next.cluster_id = 8'd0;
          qset_next              = MAX_TAXA'(qset_raw);
          cnt_next               = '0;
          case (ssmt_pkg::op_e'(request.operation))
            ssmt_pkg::OP_LOAD: begin
              if (pos_ext >= sets_eff) begin
                result_next.status = ssmt_pkg::STAT_RANGE;
                done_next          = 1'b1;
              end else begin
                // Build start: the first row loaded is the highest one.
                if (pos_ext + 10'd1 == sets_eff) begin
                  rv_valid_next = '0;
                  id_valid_next = '0;
                end
                row_next   = RW'(request.position);
                state_next = ssmt_pkg::S_LOAD;
              end
            end
            ssmt_pkg::OP_MAP: begin
              if (pos_ext >= sets_eff) begin
                result_next.status = ssmt_pkg::STAT_RANGE;
              end else begin
                id_we                   = 1'b1;
                id_valid_next[id_waddr] = 1'b1;
              end
              done_next = 1'b1;
            end
            ssmt_pkg::OP_LOOKUP, ssmt_pkg::OP_COMP_SUP, ssmt_pkg::OP_COMP: begin
              row_next   = '0;
              state_next = ssmt_pkg::S_WALK;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ssmt_pkg::S_LOAD: begin
        // Read running row of taxon cnt while writing back taxon lt.
        if (pend) begin
          jump_we           = 1'b1;
          run_we            = 1'b1;
          rv_valid_next[lt] = 1'b1;
        end
        if (cnt < taxa_n) begin
          pend_next = 1'b1;
          lt_next   = cnt_t;
          cnt_next  = cnt + CW'(1);
        end else begin
          done_next  = 1'b1;
          state_next = ssmt_pkg::S_IDLE;
        end
      end

      ssmt_pkg::S_WALK: begin
        jump_raddr = {walk_row, cnt_t};
        row_next   = walk_row;
        if (cnt < taxa_n) begin
          pend_next = qset[cnt_t];
          cnt_next  = cnt + CW'(1);
        end else begin
          cnt_next   = '0;
          match_next = 1'b1;
          state_next = ssmt_pkg::S_CHECK;
        end
      end

      ssmt_pkg::S_CHECK: begin
        // A taxon is in the row's set exactly when its entry points at the row itself.
        if (pend && ((jump_rdata == row) != qset[lt])) begin
          match_next = 1'b0;
        end
        if (cnt < taxa_n) begin
          pend_next = 1'b1;
          lt_next   = cnt_t;
          cnt_next  = cnt + CW'(1);
        end else begin
          state_next = ssmt_pkg::S_IDCHK;
        end
      end

      ssmt_pkg::S_IDCHK: begin
        if (match && row_mapped) begin
          result_next.status     = ssmt_pkg::STAT_FOUND;
          result_next.cluster_id = id_rdata;
        end else begin
          result_next.status     = ssmt_pkg::STAT_NOT_FOUND;
          result_next.cluster_id = 8'd0;
        end
        done_next  = 1'b1;
        state_next = ssmt_pkg::S_IDLE;
      end

      default: begin
        state_next = ssmt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
